[hw/rtl/mspr_pkg.sv]
`timescale 1ns / 1ps
package mspr_pkg;

  // Motor modes
  localparam logic [1:0] MODE_OFF   = 2'd0;
  localparam logic [1:0] MODE_RUN   = 2'd1;
  localparam logic [1:0] MODE_DECEL = 2'd2;
  localparam logic [1:0] MODE_SHUT  = 2'd3;

  // Speed change rate modes
  localparam logic [1:0] RATE_X0  = 2'd0;
  localparam logic [1:0] RATE_X5  = 2'd1;
  localparam logic [1:0] RATE_X10 = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_RAMP_INTERVAL = 2'd0;
  localparam logic [1:0] CFG_FRAME_LENGTH  = 2'd1;
  localparam logic [1:0] CFG_DRIVE_TICK    = 2'd2;
  localparam logic [1:0] CFG_DRIVE_GAIN    = 2'd3;

  // Configuration reset values
  localparam logic [9:0] RST_RAMP_INTERVAL = 10'd50;
  localparam logic [9:0] RST_FRAME_LENGTH  = 10'd1000;
  localparam logic [9:0] RST_DRIVE_TICK    = 10'd800;
  localparam logic [7:0] RST_DRIVE_GAIN    = 8'd40;

  localparam logic [6:0] TGT_MAX    = 7'd100;
  localparam logic [4:0] BLINK_LAST = 5'd23;
  localparam logic [4:0] X5_ON_LO   = 5'd6;
  localparam logic [4:0] X5_OFF_LO  = 5'd12;
  localparam logic [4:0] X5_ON_HI   = 5'd18;

  // One remainder step per bit of the tick counter
  localparam logic [3:0] REM_STEPS = 4'd10;

  typedef struct packed {
    logic [9:0] ramp_interval;
    logic [9:0] frame_length;
    logic [9:0] drive_update_tick;
    logic [7:0] drive_gain;
  } cfg_t;

  typedef struct packed {
    logic       target_write;
    logic [6:0] target_value;
    logic       mode_write;
    logic [1:0] mode_value;
    logic [1:0] rate_mode;
  } item_t;

  typedef struct packed {
    logic [6:0]  speed_now;
    logic [6:0]  target_now;
    logic [1:0]  mode_now;
    logic        stop_pulse;
    logic        drive_valid;
    logic [14:0] drive_value;
    logic        refresh;
    logic        target_visible;
  } result_t;

  typedef struct packed {
    logic       busy;
    logic       load;
    logic [9:0] value;
  } rem_ctl_t;

endpackage

[hw/rtl/mspr_modrem.sv]
`timescale 1ns / 1ps
// Restoring remainder, one bit per cycle: rebuilds tick mod interval after
// a configuration write.
module mspr_modrem (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [9:0]          dividend,
  input  logic [9:0]          divisor,
  output mspr_pkg::rem_ctl_t  ctl
);

  logic       pend;
  logic [3:0] cnt;
  logic       done;
  logic [9:0] rem;
  logic [9:0] dvd;
  logic [9:0] dvs;
  logic [10:0] trial;
  logic [10:0] diff;
  logic [9:0]  rem_next;

  always_comb begin
    trial = {rem, dvd[9]};
    diff  = trial - {1'b0, dvs};
    if (trial >= {1'b0, dvs}) begin
      rem_next = diff[9:0];
    end else begin
      rem_next = trial[9:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
      cnt  <= 4'd0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        // take the operands in the next cycle, with the new value in place
        pend <= 1'b1;
        cnt  <= 4'd0;
      end else if (pend) begin
        pend <= 1'b0;
        cnt  <= mspr_pkg::REM_STEPS;
      end else if (cnt != 4'd0) begin
        cnt <= cnt - 4'd1;
        if (cnt == 4'd1) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pend) begin
      rem <= 10'd0;
      dvd <= dividend;
      dvs <= divisor;
    end else if (cnt != 4'd0) begin
      rem <= rem_next;
      dvd <= {dvd[8:0], 1'b0};
    end
  end

  assign ctl.busy  = pend | (cnt != 4'd0) | done;
  assign ctl.load  = done;
  assign ctl.value = rem;

endmodule

[hw/rtl/mspr_core.sv]
`timescale 1ns / 1ps
// Tick state and the per-tick update; the result is combinational from the
// accepted item and the current state.
module mspr_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  mspr_pkg::item_t     item,
  input  mspr_pkg::cfg_t      cfg,
  input  logic [9:0]          interval,
  input  mspr_pkg::rem_ctl_t  rem,
  output mspr_pkg::result_t   res,
  output logic [9:0]          tick_count
);

  logic [9:0] phase;
  logic [6:0] speed_level;
  logic [6:0] target_level;
  logic [1:0] motor_mode;
  logic [4:0] blink_count;

  logic [9:0]  tick_count_next;
  logic [9:0]  phase_next;
  logic [6:0]  speed_level_next;
  logic [6:0]  target_level_next;
  logic [1:0]  motor_mode_next;
  logic [4:0]  blink_count_next;

  logic [6:0]  tgt_in;
  logic [1:0]  mode_in;
  logic        ramp;
  logic        stop;
  logic        visible;
  logic        blink_on_x5;
  logic [10:0] tick_inc;
  logic [10:0] phase_inc;
  logic [14:0] product;

  always_comb begin
    // Apply the request's writes before the tick
    if (item.target_write) begin
      tgt_in = (item.target_value > mspr_pkg::TGT_MAX) ? mspr_pkg::TGT_MAX
                                                       : item.target_value;
    end else begin
      tgt_in = target_level;
    end
    mode_in = item.mode_write ? item.mode_value : motor_mode;

    ramp              = (phase == 10'd0);
    stop              = 1'b0;
    target_level_next = tgt_in;
    motor_mode_next   = mode_in;
    if (ramp && (mode_in == mspr_pkg::MODE_DECEL)) begin
      if (tgt_in == 7'd0) begin
        motor_mode_next = mspr_pkg::MODE_SHUT;
        stop            = 1'b1;
      end else begin
        target_level_next = tgt_in - 7'd1;
      end
    end

    speed_level_next = speed_level;
    if (ramp) begin
      if (speed_level < target_level_next) begin
        speed_level_next = speed_level + 7'd1;
      end else if (speed_level > target_level_next) begin
        speed_level_next = speed_level - 7'd1;
      end
    end

    // mod 12 < 6 over a 0..23 count
    blink_on_x5 = blink_count inside {[5'd0 : mspr_pkg::X5_ON_LO - 5'd1],
                                      [mspr_pkg::X5_OFF_LO : mspr_pkg::X5_ON_HI - 5'd1]};

    visible          = 1'b0;
    blink_count_next = blink_count;
    if (ramp && (motor_mode_next != mspr_pkg::MODE_OFF)) begin
      case (item.rate_mode)
        mspr_pkg::RATE_X0:  visible = 1'b1;
        mspr_pkg::RATE_X5:  visible = blink_on_x5;
        mspr_pkg::RATE_X10: visible = ~blink_count[1];
        default:            visible = 1'b0;
      endcase
      blink_count_next = (blink_count >= mspr_pkg::BLINK_LAST) ? 5'd0
                                                               : blink_count + 5'd1;
    end

    product = {8'd0, speed_level_next} * {7'd0, cfg.drive_gain};

    tick_inc  = {1'b0, tick_count} + 11'd1;
    phase_inc = {1'b0, phase} + 11'd1;
    if (tick_inc >= {1'b0, cfg.frame_length}) begin
      tick_count_next = 10'd0;
      phase_next      = 10'd0;
    end else begin
      tick_count_next = tick_inc[9:0];
      phase_next      = (phase_inc >= {1'b0, interval}) ? 10'd0 : phase_inc[9:0];
    end

    res.speed_now      = speed_level_next;
    res.target_now     = target_level_next;
    res.mode_now       = motor_mode_next;
    res.stop_pulse     = stop;
    res.drive_valid    = (tick_count == cfg.drive_update_tick);
    res.drive_value    = res.drive_valid ? product : 15'd0;
    res.refresh        = ramp;
    res.target_visible = visible;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count   <= 10'd0;
      phase        <= 10'd0;
      speed_level  <= 7'd0;
      target_level <= 7'd0;
      motor_mode   <= mspr_pkg::MODE_OFF;
      blink_count  <= 5'd0;
    end else if (rem.load) begin
      phase <= rem.value;
    end else if (accept) begin
      tick_count   <= tick_count_next;
      phase        <= phase_next;
      speed_level  <= speed_level_next;
      target_level <= target_level_next;
      motor_mode   <= motor_mode_next;
      blink_count  <= blink_count_next;
    end
  end

  a_target_range: assert property (@(posedge clk) disable iff (rst)
    target_level <= mspr_pkg::TGT_MAX)
    else $error("target above range");

  a_blink_range: assert property (@(posedge clk) disable iff (rst)
    blink_count <= mspr_pkg::BLINK_LAST)
    else $error("blink counter out of range");

  a_stop_shut: assert property (@(posedge clk) disable iff (rst)
    (accept && !rem.load && res.stop_pulse) |=>
      (motor_mode == mspr_pkg::MODE_SHUT) && (target_level == 7'd0))
    else $error("stop pulse without shutdown");

endmodule

[hw/rtl/mspr_outq.sv]
`timescale 1ns / 1ps
// Two-entry result queue: lets a new tick in while a result waits.
module mspr_outq (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  mspr_pkg::result_t  din,
  input  logic               pop,
  output mspr_pkg::result_t  dout,
  output logic               valid,
  output logic               full
);

  mspr_pkg::result_t mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  assign dout  = mem[rd_ptr];
  assign valid = (count != 2'd0);
  assign full  = (count == 2'd2);

endmodule

[hw/rtl/motor_speed_ramp_ticker.sv]
`timescale 1ns / 1ps
// Channel | direction | handshake             | payload
// --------+-----------+-----------------------+------------------------------------
// in      | request   | in_valid / in_stall   | target_write, target_value,
//         |           |                       | mode_write, mode_value, rate_mode
// out     | result    | out_valid / out_stall | speed_now, target_now, mode_now,
//         |           |                       | stop_pulse, drive_valid, drive_value,
//         |           |                       | refresh, target_visible
// cfg     | write     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One tick request is taken per clock while in_stall is low; its result is in
// the output queue on the next cycle, so an uncongested ramp runs at one tick
// per cycle. A configuration write starts a rebuild of the ramp phase (tick
// count mod ramp interval, one bit per cycle); requests are held off for it.
// Reset (rst, synchronous) clears the tick, speed, target, mode and blink
// state and reloads the register defaults.
// A stalled output queue holds two results; in_stall rises once both are full.
module motor_speed_ramp_ticker (
  input  logic        clk,
  input  logic        rst,
  // tick request
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        target_write,
  input  logic [6:0]  target_value,
  input  logic        mode_write,
  input  logic [1:0]  mode_value,
  input  logic [1:0]  rate_mode,
  // tick result
  output logic        out_valid,
  input  logic        out_stall,
  output logic [6:0]  speed_now,
  output logic [6:0]  target_now,
  output logic [1:0]  mode_now,
  output logic        stop_pulse,
  output logic        drive_valid,
  output logic [14:0] drive_value,
  output logic        refresh,
  output logic        target_visible,
  // register writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [9:0]  cfg_data
);

  mspr_pkg::cfg_t     cfg;
  mspr_pkg::item_t    item;
  mspr_pkg::result_t  res;
  mspr_pkg::result_t  q_dout;
  mspr_pkg::rem_ctl_t rem_ctl;

  logic       cfg_wr;
  logic       accept;
  logic       pop;
  logic       q_full;
  logic [9:0] interval;
  logic [9:0] tick_count;

  // Registers are always writable; the phase rebuild follows any write
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid & cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ramp_interval     <= mspr_pkg::RST_RAMP_INTERVAL;
      cfg.frame_length      <= mspr_pkg::RST_FRAME_LENGTH;
      cfg.drive_update_tick <= mspr_pkg::RST_DRIVE_TICK;
      cfg.drive_gain        <= mspr_pkg::RST_DRIVE_GAIN;
    end else if (cfg_wr) begin
      case (cfg_index)
        mspr_pkg::CFG_RAMP_INTERVAL: cfg.ramp_interval     <= cfg_data;
        mspr_pkg::CFG_FRAME_LENGTH:  cfg.frame_length      <= cfg_data;
        mspr_pkg::CFG_DRIVE_TICK:    cfg.drive_update_tick <= cfg_data;
        mspr_pkg::CFG_DRIVE_GAIN:    cfg.drive_gain        <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // A zero interval ramps on every tick
  assign interval = (cfg.ramp_interval == 10'd0) ? 10'd1 : cfg.ramp_interval;

  // Hold requests while the phase is rebuilt or both queue slots are taken
  assign in_stall = rem_ctl.busy | q_full;
  assign accept   = in_valid & ~in_stall;
  assign pop      = out_valid & ~out_stall;

  assign item.target_write = target_write;
  assign item.target_value = target_value;
  assign item.mode_write   = mode_write;
  assign item.mode_value   = mode_value;
  assign item.rate_mode    = rate_mode;

  mspr_modrem u_modrem (
    .clk      (clk),
    .rst      (rst),
    .start    (cfg_wr),
    .dividend (tick_count),
    .divisor  (interval),
    .ctl      (rem_ctl)
  );

  mspr_core u_core (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .item       (item),
    .cfg        (cfg),
    .interval   (interval),
    .rem        (rem_ctl),
    .res        (res),
    .tick_count (tick_count)
  );

  mspr_outq u_outq (
    .clk   (clk),
    .rst   (rst),
    .push  (accept),
    .din   (res),
    .pop   (pop),
    .dout  (q_dout),
    .valid (out_valid),
    .full  (q_full)
  );

  assign speed_now      = q_dout.speed_now;
  assign target_now     = q_dout.target_now;
  assign mode_now       = q_dout.mode_now;
  assign stop_pulse     = q_dout.stop_pulse;
  assign drive_valid    = q_dout.drive_valid;
  assign drive_value    = q_dout.drive_value;
  assign refresh        = q_dout.refresh;
  assign target_visible = q_dout.target_visible;

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking bench for the motor speed ramp ticker.
//
// Each tick request is predicted at the clock edge that accepts it. The bench
// keeps its own model of the tick counter, the speed, the target, the motor
// mode and the blink phase. The predicted result is queued and compared, field
// by field, with the next result that the block hands over.
//
// The run goes through these parts:
//   - directed ticks: the default registers, target saturation, every motor
//     mode and rate mode, blink hold while powered off, and deceleration down
//     to the stop pulse;
//   - counter corners: zero ramp interval, zero frame length, a frame that is
//     cut short under a running counter, and a drive tick that is never
//     reached;
//   - random phases: fresh register values for each phase, extremes included,
//     with random ticks, and random idling on both sides in all but one phase;
//   - output backpressure: a long receiver hold-off while ticks keep coming,
//     so that the output queue fills and the input stalls.
module tb_top;
  import mspr_pkg::*;

  localparam int          CLK_HALF       = 6;
  localparam int          CYCLE_LIMIT    = 250000;
  localparam int          SETTLE_CYCLES  = 8;
  localparam int          LONG_HOLD      = 300;
  localparam int          PHASES         = 10;
  localparam int          PHASE_TICKS    = 100;
  localparam int          MAX_REPORTS    = 40;
  localparam logic [1:0]  RATE_UNDEFINED = 2'd3;
  localparam int          BLINK_X5_PERIOD  = 12;
  localparam int          BLINK_X5_ON      = 6;
  localparam int          BLINK_X10_PERIOD = 4;
  localparam int          BLINK_X10_ON     = 2;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic        target_write;
  logic [6:0]  target_value;
  logic        mode_write;
  logic [1:0]  mode_value;
  logic [1:0]  rate_mode;
  logic        out_valid;
  logic        out_stall;
  logic [6:0]  speed_now;
  logic [6:0]  target_now;
  logic [1:0]  mode_now;
  logic        stop_pulse;
  logic        drive_valid;
  logic [14:0] drive_value;
  logic        refresh;
  logic        target_visible;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [9:0]  cfg_data;

  motor_speed_ramp_ticker dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .target_write   (target_write),
    .target_value   (target_value),
    .mode_write     (mode_write),
    .mode_value     (mode_value),
    .rate_mode      (rate_mode),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .speed_now      (speed_now),
    .target_now     (target_now),
    .mode_now       (mode_now),
    .stop_pulse     (stop_pulse),
    .drive_valid    (drive_valid),
    .drive_value    (drive_value),
    .refresh        (refresh),
    .target_visible (target_visible),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // Predicted state of the block and its registers.
  cfg_t       ramp_cfg;
  logic [9:0] tick_pos;
  logic [6:0] speed_pct;
  logic [6:0] target_pct;
  logic [1:0] motor_state;
  logic [4:0] blink_phase;

  // Results predicted for accepted ticks, oldest first.
  result_t tick_results_due[$];

  // Idling knobs, set by the test tasks and read by the sender and receiver.
  int gap_pct;
  int max_gap;
  int max_burst;
  int burst_left;
  int stall_pct;
  int max_stall_run;
  int hold_requests;

  // Run statistics.
  int mismatch_count;
  int ticks_sent;
  int results_seen;
  int ramp_steps;
  int stop_pulses;
  int drive_updates;
  int settings_used;
  int cycle_cnt;

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Advance the predicted state by one tick and return the expected result.
  function automatic result_t advance_ramp(input item_t t);
    result_t     r;
    int unsigned interval;
    int unsigned next_tick;
    r = '0;
    interval = (ramp_cfg.ramp_interval == 10'd0) ? 1 : ramp_cfg.ramp_interval;
    // Load the writes that come with the tick before anything else moves.
    if (t.target_write) begin
      target_pct = (t.target_value > TGT_MAX) ? TGT_MAX : t.target_value;
    end
    if (t.mode_write) begin
      motor_state = t.mode_value;
    end
    if (tick_pos % interval == 0) begin
      // Deceleration drains the target first; a target already at zero stops.
      if (motor_state == MODE_DECEL) begin
        if (target_pct == 7'd0) begin
          motor_state  = MODE_SHUT;
          r.stop_pulse = 1'b1;
        end else begin
          target_pct = target_pct - 7'd1;
        end
      end
      if (speed_pct < target_pct) begin
        speed_pct = speed_pct + 7'd1;
      end else if (speed_pct > target_pct) begin
        speed_pct = speed_pct - 7'd1;
      end
      r.refresh = 1'b1;
      // Hold the blink phase while powered off; the target is not drawn then.
      if (motor_state != MODE_OFF) begin
        case (t.rate_mode)
          RATE_X0:  r.target_visible = 1'b1;
          RATE_X5:  r.target_visible = (blink_phase % BLINK_X5_PERIOD) < BLINK_X5_ON;
          RATE_X10: r.target_visible = (blink_phase % BLINK_X10_PERIOD) < BLINK_X10_ON;
          default:  r.target_visible = 1'b0;
        endcase
        blink_phase = (blink_phase >= BLINK_LAST) ? 5'd0 : blink_phase + 5'd1;
      end
    end
    if (tick_pos == ramp_cfg.drive_update_tick) begin
      r.drive_valid = 1'b1;
      r.drive_value = speed_pct * ramp_cfg.drive_gain;
    end
    // Wrap on reaching or passing the frame length, so a shortened frame
    // restarts on the next tick.
    next_tick = tick_pos + 1;
    tick_pos  = (next_tick >= ramp_cfg.frame_length) ? 10'd0 : next_tick[9:0];
    r.speed_now  = speed_pct;
    r.target_now = target_pct;
    r.mode_now   = motor_state;
    return r;
  endfunction

  function automatic item_t make_tick(input bit tw, input int tv, input bit mw,
                                      input logic [1:0] mv, input logic [1:0] rate);
    item_t t;
    t.target_write = tw;
    t.target_value = tv[6:0];
    t.mode_write   = mw;
    t.mode_value   = mv;
    t.rate_mode    = rate;
    return t;
  endfunction

  // Mostly running and decelerating, with sparse writes so that ramps and
  // deceleration have room to run their course.
  function automatic item_t random_tick();
    item_t t;
    int    pick;
    t.target_write = ($urandom_range(0, 11) == 0);
    t.target_value = ($urandom_range(0, 7) == 0) ? 7'($urandom_range(101, 127))
                                                 : 7'($urandom_range(0, 100));
    t.mode_write   = ($urandom_range(0, 19) == 0);
    pick = $urandom_range(0, 19);
    t.mode_value   = (pick < 8)  ? MODE_RUN :
                     (pick < 15) ? MODE_DECEL :
                     (pick < 18) ? MODE_OFF : MODE_SHUT;
    t.rate_mode    = ($urandom_range(0, 9) == 0) ? RATE_UNDEFINED : 2'($urandom_range(0, 2));
    return t;
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatch_count < MAX_REPORTS) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) begin
      report_mismatch($sformatf("result %0d %s = %0d, expected %0d",
                                results_seen, name, got, want));
    end
  endtask

  // Offer one tick request in bursts with random gaps, then predict it once
  // the block takes it.
  task automatic send_tick(input item_t t);
    int      gap;
    result_t due;
    @(negedge clk);
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, max_burst);
      gap = (gap_pct > 0 && $urandom_range(1, 100) <= gap_pct) ? $urandom_range(1, max_gap) : 0;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid     <= 1'b1;
    target_write <= t.target_write;
    target_value <= t.target_value;
    mode_write   <= t.mode_write;
    mode_value   <= t.mode_value;
    rate_mode    <= t.rate_mode;
    do @(posedge clk); while (in_stall);
    due = advance_ramp(t);
    tick_results_due.push_back(due);
    ticks_sent++;
  endtask

  // Drop the request line and wait until every predicted result is back.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (tick_results_due.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input int val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[9:0];
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_RAMP_INTERVAL: ramp_cfg.ramp_interval     = val[9:0];
      CFG_FRAME_LENGTH:  ramp_cfg.frame_length      = val[9:0];
      CFG_DRIVE_TICK:    ramp_cfg.drive_update_tick = val[9:0];
      default:           ramp_cfg.drive_gain        = val[7:0];
    endcase
  endtask

  // Write all four registers back to back; only called with nothing in flight.
  task automatic write_regs(input int interval, input int frame, input int drive_tick,
                            input int gain);
    write_reg(CFG_RAMP_INTERVAL, interval);
    write_reg(CFG_FRAME_LENGTH, frame);
    write_reg(CFG_DRIVE_TICK, drive_tick);
    write_reg(CFG_DRIVE_GAIN, gain);
    @(negedge clk);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  task automatic set_idling(input int send_gap_pct, input int recv_stall_pct);
    gap_pct       = send_gap_pct;
    max_gap       = $urandom_range(1, 8);
    max_burst     = $urandom_range(1, 12);
    burst_left    = 0;
    stall_pct     = recv_stall_pct;
    max_stall_run = $urandom_range(1, 8);
  endtask

  // Default registers, saturation, every mode and rate, blink hold while
  // powered off and deceleration through to the stop pulse.
  task automatic test_directed_ticks();
    set_idling(30, 30);
    // Defaults: tick zero is a ramp tick under the reset interval.
    send_tick(make_tick(1, 3, 1, MODE_RUN, RATE_X0));
    send_tick(make_tick(0, 0, 0, MODE_OFF, RATE_X5));
    settle();
    write_regs(1, 8, 3, 255);
    send_tick(make_tick(1, 127, 1, MODE_RUN, RATE_X0));
    send_tick(make_tick(1, 101, 0, MODE_OFF, RATE_X5));
    send_tick(make_tick(0, 0, 0, MODE_OFF, RATE_X10));
    send_tick(make_tick(0, 0, 0, MODE_OFF, RATE_UNDEFINED));
    send_tick(make_tick(0, 0, 1, MODE_OFF, RATE_X5));
    send_tick(make_tick(0, 0, 1, MODE_SHUT, RATE_X10));
    // Decelerate from a small target: two steps down, then the stop.
    send_tick(make_tick(1, 2, 1, MODE_DECEL, RATE_X0));
    send_tick(make_tick(0, 0, 0, MODE_OFF, RATE_X0));
    send_tick(make_tick(0, 0, 0, MODE_OFF, RATE_X0));
    // Decelerating with a zero target stops on the same tick.
    send_tick(make_tick(1, 0, 1, MODE_DECEL, RATE_X5));
    send_tick(make_tick(1, 100, 1, MODE_RUN, RATE_X10));
    settle();
  endtask

  // Zero interval and frame, a frame cut short under the counter and a drive
  // tick that lies beyond the frame.
  task automatic test_counter_corners();
    int i;
    set_idling(20, 20);
    write_regs(0, 0, 0, 0);
    for (i = 0; i < 3; i++) send_tick(make_tick(i == 0, 60, i == 0, MODE_RUN, 2'(i)));
    settle();
    write_regs(2, 12, 10, 200);
    for (i = 0; i < 5; i++) send_tick(random_tick());
    settle();
    // The counter now sits past the new frame end and must wrap next tick;
    // the drive tick can no longer be reached.
    write_regs(1, 3, 10, 255);
    for (i = 0; i < 3; i++) send_tick(random_tick());
    settle();
  endtask

  // Random registers per phase, extremes included, with random ticks.
  task automatic test_random_ramp();
    int phase;
    int i;
    int frame;
    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: write_regs(1, 1000, 999, 255);
        1: write_regs(1000, 1000, 0, 0);
        2: write_regs(1023, 1023, 1023, 128);
        3: write_regs(1, 1, 0, 255);
        default: begin
          frame = $urandom_range(1, 60);
          write_regs($urandom_range(1, 6), frame, $urandom_range(0, frame + 3),
                     $urandom_range(0, 255));
        end
      endcase
      // Keep one phase free of idling on both sides.
      if (phase == 4) begin
        set_idling(0, 0);
      end else begin
        set_idling($urandom_range(0, 60), $urandom_range(0, 60));
      end
      for (i = 0; i < PHASE_TICKS; i++) send_tick(random_tick());
      settle();
    end
  endtask

  // Hold the result side off for a long stretch while ticks keep coming.
  task automatic test_output_backpressure();
    int i;
    write_regs(1, 16, 5, 77);
    set_idling(0, 0);
    hold_requests++;
    for (i = 0; i < 40; i++) send_tick(random_tick());
    settle();
  endtask

  // Receiver: stall in runs of random length, or for a long hold-off on request.
  initial begin : result_side
    int hold_left;
    int run_left;
    int hold_seen;
    hold_left = 0;
    run_left  = 0;
    hold_seen = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_requests != hold_seen) begin
        hold_seen = hold_requests;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (run_left > 0) begin
        run_left--;
      end else begin
        run_left  = $urandom_range(0, max_stall_run - 1);
        out_stall <= (stall_pct > 0 && $urandom_range(1, 100) <= stall_pct);
      end
    end
  end

  // Compare each accepted result with the oldest prediction.
  always @(posedge clk) begin : result_check
    result_t due;
    if (!rst && out_valid && !out_stall) begin
      if (tick_results_due.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with no tick outstanding",
                                  results_seen));
      end else begin
        due = tick_results_due.pop_front();
        check_field("speed_now", speed_now, due.speed_now);
        check_field("target_now", target_now, due.target_now);
        check_field("mode_now", mode_now, due.mode_now);
        check_field("stop_pulse", stop_pulse, due.stop_pulse);
        check_field("drive_valid", drive_valid, due.drive_valid);
        check_field("drive_value", drive_value, due.drive_value);
        check_field("refresh", refresh, due.refresh);
        check_field("target_visible", target_visible, due.target_visible);
        ramp_steps    += due.refresh;
        stop_pulses   += due.stop_pulse;
        drive_updates += due.drive_valid;
      end
      results_seen++;
    end
  end

  // Give up on a hung run.
  initial begin : watchdog
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles, %0d results outstanding",
             cycle_cnt, tick_results_due.size());
    $display("** motor_speed_ramp_ticker: FAILED **");
    $finish;
  end

  initial begin : run
    int wait_cycles;
    // Drive every input to a known value before the first edge.
    rst            = 1'b1;
    in_valid       = 1'b0;
    target_write   = 1'b0;
    target_value   = 7'd0;
    mode_write     = 1'b0;
    mode_value     = MODE_OFF;
    rate_mode      = RATE_X0;
    cfg_valid      = 1'b0;
    cfg_index      = CFG_RAMP_INTERVAL;
    cfg_data       = 10'd0;
    mismatch_count = 0;
    ticks_sent     = 0;
    results_seen   = 0;
    ramp_steps     = 0;
    stop_pulses    = 0;
    drive_updates  = 0;
    settings_used  = 1;
    hold_requests  = 0;
    set_idling(0, 0);
    // Reset state of the prediction.
    ramp_cfg.ramp_interval     = RST_RAMP_INTERVAL;
    ramp_cfg.frame_length      = RST_FRAME_LENGTH;
    ramp_cfg.drive_update_tick = RST_DRIVE_TICK;
    ramp_cfg.drive_gain        = RST_DRIVE_GAIN;
    tick_pos    = 10'd0;
    speed_pct   = 7'd0;
    target_pct  = 7'd0;
    motor_state = MODE_OFF;
    blink_phase = 5'd0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_ticks();
    test_counter_corners();
    test_random_ramp();
    test_output_backpressure();

    // Final drain, bounded, then a quiet settle wait to catch stray results.
    @(negedge clk);
    in_valid <= 1'b0;
    wait_cycles = 0;
    while (tick_results_due.size() > 0 && wait_cycles < 2000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tick_results_due.size() > 0) begin
      report_mismatch($sformatf("%0d results never arrived", tick_results_due.size()));
    end

    $display("ran %0d ticks under %0d register settings in %0d cycles",
             ticks_sent, settings_used, cycle_cnt);
    $display("saw %0d ramp steps, %0d stop pulses, %0d drive updates, %0d mismatches",
             ramp_steps, stop_pulses, drive_updates, mismatch_count);
    if (mismatch_count == 0) begin
      $display("** motor_speed_ramp_ticker: PASSED **");
    end else begin
      $display("** motor_speed_ramp_ticker: FAILED **");
    end
    $finish;
  end

endmodule
